>>> rtl/core/dpdpc_pkg.sv
package dpdpc_pkg;

  // Configuration register indexes, in the order of the register map.
  typedef enum logic [2:0] {
    REG_CENTER_X     = 3'd0,
    REG_CENTER_Y     = 3'd1,
    REG_INV_FOCAL_X  = 3'd2,
    REG_INV_FOCAL_Y  = 3'd3,
    REG_PLANE_A      = 3'd4,
    REG_PLANE_B      = 3'd5,
    REG_PLANE_C      = 3'd6,
    REG_PLANE_OFFSET = 3'd7
  } cfg_reg_e;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;

  localparam int CENTER_BITS = 16;
  localparam int INV_BITS    = 24;
  localparam int PLANE_BITS  = 32;
  localparam int OFFSET_BITS = 24;
  localparam int COORD_W     = 24;
  localparam int FORWARD_W   = 16;

  // Q4 pixel times Q24 reciprocal gives Q28; results are rounded to mm.
  localparam int Q4_SHIFT    = 4;
  localparam int ROUND_SHIFT = 28;
  localparam int PLANE_SHIFT = 16;

  localparam logic signed [COORD_W-1:0] SAT_MAX = 24'sh7FFFFF;
  localparam logic signed [COORD_W-1:0] SAT_MIN = 24'sh800000;

  localparam int HEIGHT_MIN_MM = 50;

  localparam logic [CENTER_BITS-1:0] CENTER_X_RST  = 16'd5120;
  localparam logic [CENTER_BITS-1:0] CENTER_Y_RST  = 16'd3840;
  localparam logic [INV_BITS-1:0]    INV_FOCAL_RST = 24'd27962;

  // Stage load enables for the coordinate lanes and the height unit.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } axis_en_t;

  typedef struct packed {
    logic s4;
    logic s5;
  } height_en_t;

endpackage

>>> rtl/core/dpdpc_in_if.sv
interface dpdpc_in_if #(
  parameter int COORD_BITS = 12,
  parameter int DEPTH_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [DEPTH_BITS-1:0] depth_mm;
  logic [COORD_BITS-1:0] pixel_col;
  logic [COORD_BITS-1:0] pixel_row;
  logic                  frame_last;

  modport source (output valid, depth_mm, pixel_col, pixel_row, frame_last, input ready);
  modport sink (input valid, depth_mm, pixel_col, pixel_row, frame_last, output ready);
endinterface

>>> rtl/core/dpdpc_out_if.sv
interface dpdpc_out_if;
  logic               valid;
  logic               ready;
  logic               keep;
  logic [15:0]        point_forward;
  logic signed [23:0] point_left;
  logic signed [23:0] point_up;
  logic               result_last;

  modport source (output valid, keep, point_forward, point_left, point_up, result_last,
                  input ready);
  modport sink (input valid, keep, point_forward, point_left, point_up, result_last,
                output ready);
endinterface

>>> rtl/core/depth_pixel_deproject_plane_clip_core.sv
// Depth pixel deprojection with a height clip. Each transfer on in_ch carries one depth
// pixel in mm with its column and row; the block turns it through the pinhole model into
// a point (forward = depth, left and up = negated lateral and vertical offsets, rounded
// to mm and clamped to 24 bits) and sets keep when depth is nonzero and the plane height
// a*forward + b*left + c*up (Q16) plus the offset in mm is at least 50 mm. Exactly one
// result leaves on out_ch per pixel, in order, with frame_last copied to result_last.
// The pipeline has five register stages, with a 34x25 reciprocal multiply in the
// second, and takes one pixel per cycle while out_ch accepts results. Backpressure
// on out_ch holds the pipeline only where stages are full, so bubbles are squeezed
// out before in_ch.ready drops.
// Configuration registers are written through cfg_we, cfg_index and cfg_wdata and must
// only change while no pixel is in flight.
module depth_pixel_deproject_plane_clip_core
  import dpdpc_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int DEPTH_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  dpdpc_in_if.sink                 in_ch,
  dpdpc_out_if.source              out_ch,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  localparam int STAGES = 5;

  // Configuration registers.
  logic [CENTER_BITS-1:0]        center_x_r;
  logic [CENTER_BITS-1:0]        center_y_r;
  logic [INV_BITS-1:0]           inv_fx_r;
  logic [INV_BITS-1:0]           inv_fy_r;
  logic signed [PLANE_BITS-1:0]  plane_a_r;
  logic signed [PLANE_BITS-1:0]  plane_b_r;
  logic signed [PLANE_BITS-1:0]  plane_c_r;
  logic signed [OFFSET_BITS-1:0] plane_off_r;

  // Stage control: a stage loads whenever it is empty or its successor loads.
  logic [STAGES-1:0] stg_v_r;
  logic [STAGES-1:0] stg_v_nxt;
  logic [STAGES-1:0] stg_rdy;

  // Side payload that travels alongside the arithmetic.
  logic [DEPTH_BITS-1:0]     dep_pipe_r  [STAGES];
  logic                      last_pipe_r [STAGES];
  logic signed [COORD_W-1:0] left3;
  logic signed [COORD_W-1:0] up3;
  logic signed [COORD_W-1:0] left4_r;
  logic signed [COORD_W-1:0] up4_r;
  logic signed [COORD_W-1:0] left5_r;
  logic signed [COORD_W-1:0] up5_r;
  logic                      keep5;

  axis_en_t   axis_en;
  height_en_t height_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r  <= CENTER_X_RST;
      center_y_r  <= CENTER_Y_RST;
      inv_fx_r    <= INV_FOCAL_RST;
      inv_fy_r    <= INV_FOCAL_RST;
      plane_a_r   <= '0;
      plane_b_r   <= '0;
      plane_c_r   <= '0;
      plane_off_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTER_X:     center_x_r  <= cfg_wdata[CENTER_BITS-1:0];
        REG_CENTER_Y:     center_y_r  <= cfg_wdata[CENTER_BITS-1:0];
        REG_INV_FOCAL_X:  inv_fx_r    <= cfg_wdata[INV_BITS-1:0];
        REG_INV_FOCAL_Y:  inv_fy_r    <= cfg_wdata[INV_BITS-1:0];
        REG_PLANE_A:      plane_a_r   <= cfg_wdata[PLANE_BITS-1:0];
        REG_PLANE_B:      plane_b_r   <= cfg_wdata[PLANE_BITS-1:0];
        REG_PLANE_C:      plane_c_r   <= cfg_wdata[PLANE_BITS-1:0];
        REG_PLANE_OFFSET: plane_off_r <= cfg_wdata[OFFSET_BITS-1:0];
        default: ;
      endcase
    end
  end

  // The ready chain runs from the output back to the input, one term per stage.
  always_comb begin
    stg_rdy[STAGES-1] = !stg_v_r[STAGES-1] || out_ch.ready;
    for (int i = STAGES - 2; i >= 0; i--) begin
      stg_rdy[i] = !stg_v_r[i] || stg_rdy[i+1];
    end
    stg_v_nxt[0] = stg_rdy[0] ? in_ch.valid : stg_v_r[0];
    for (int i = 1; i < STAGES; i++) begin
      stg_v_nxt[i] = stg_rdy[i] ? stg_v_r[i-1] : stg_v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= '0;
    end else begin
      stg_v_r <= stg_v_nxt;
    end
  end

  // Payload registers take no reset; a bubble simply carries stale data.
  always_ff @(posedge clk) begin
    if (stg_rdy[0]) begin
      dep_pipe_r[0]  <= in_ch.depth_mm;
      last_pipe_r[0] <= in_ch.frame_last;
    end
    for (int i = 1; i < STAGES; i++) begin
      if (stg_rdy[i]) begin
        dep_pipe_r[i]  <= dep_pipe_r[i-1];
        last_pipe_r[i] <= last_pipe_r[i-1];
      end
    end
    if (stg_rdy[3]) begin
      left4_r <= left3;
      up4_r   <= up3;
    end
    if (stg_rdy[4]) begin
      left5_r <= left4_r;
      up5_r   <= up4_r;
    end
  end

  assign axis_en   = '{s1: stg_rdy[0], s2: stg_rdy[1], s3: stg_rdy[2]};
  assign height_en = '{s4: stg_rdy[3], s5: stg_rdy[4]};

  // Stages 1 to 3: lateral and vertical lanes side by side.
  dpdpc_axis #(
    .PIX_BITS   (COORD_BITS),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_axis_x (
    .clk     (clk),
    .en      (axis_en),
    .depth   (in_ch.depth_mm),
    .pix     (in_ch.pixel_col),
    .center  (center_x_r),
    .inv     (inv_fx_r),
    .coord_r (left3)
  );

  dpdpc_axis #(
    .PIX_BITS   (COORD_BITS),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_axis_y (
    .clk     (clk),
    .en      (axis_en),
    .depth   (in_ch.depth_mm),
    .pix     (in_ch.pixel_row),
    .center  (center_y_r),
    .inv     (inv_fy_r),
    .coord_r (up3)
  );

  // Stages 4 and 5: plane weights, then the summed height and the keep decision.
  dpdpc_height #(
    .DEPTH_BITS (DEPTH_BITS)
  ) u_height (
    .clk     (clk),
    .en      (height_en),
    .forward (dep_pipe_r[2]),
    .left    (left3),
    .up      (up3),
    .plane_a (plane_a_r),
    .plane_b (plane_b_r),
    .plane_c (plane_c_r),
    .offset  (plane_off_r),
    .keep_r  (keep5)
  );

  assign in_ch.ready          = stg_rdy[0];
  assign out_ch.valid         = stg_v_r[STAGES-1];
  assign out_ch.keep          = keep5;
  assign out_ch.point_forward = FORWARD_W'(dep_pipe_r[STAGES-1]);
  assign out_ch.point_left    = left5_r;
  assign out_ch.point_up      = up5_r;
  assign out_ch.result_last   = last_pipe_r[STAGES-1];

endmodule

>>> rtl/core/dpdpc_axis.sv
module dpdpc_axis
  import dpdpc_pkg::*;
#(
  parameter int PIX_BITS   = 12,
  parameter int DEPTH_BITS = 16
) (
  input  logic                      clk,
  input  axis_en_t                  en,
  input  logic [DEPTH_BITS-1:0]     depth,
  input  logic [PIX_BITS-1:0]       pix,
  input  logic [CENTER_BITS-1:0]    center,
  input  logic [INV_BITS-1:0]       inv,
  output logic signed [COORD_W-1:0] coord_r
);

  localparam int PQ  = PIX_BITS + Q4_SHIFT;
  localparam int DW  = ((PQ > CENTER_BITS) ? PQ : CENTER_BITS) + 1;
  localparam int PW1 = DEPTH_BITS + 1 + DW;
  localparam int PW2 = PW1 + INV_BITS + 1;
  localparam int RW  = PW2 - ROUND_SHIFT;
  localparam int NW  = ((RW > COORD_W) ? RW : COORD_W) + 1;

  logic signed [DW-1:0]  diff;
  logic signed [PW1-1:0] prod1_nxt;
  logic signed [PW1-1:0] prod1_r;
  logic signed [PW2-1:0] prod2_r;
  logic signed [PW2-1:0] biased;
  logic signed [RW-1:0]  rnd;
  logic signed [NW-1:0]  neg;
  logic signed [COORD_W-1:0] coord_nxt;

  // Stage 1: offset from the principal point in Q4, then scale by depth.
  always_comb begin
    diff = $signed({{(DW-PQ){1'b0}}, pix, {Q4_SHIFT{1'b0}}})
         - $signed({{(DW-CENTER_BITS){1'b0}}, center});
    prod1_nxt = $signed({1'b0, depth}) * diff;
  end

  // Stage 3: round half up, negate, then clamp to 24 bits.
  always_comb begin
    biased = prod2_r + $signed(PW2'(1) <<< (ROUND_SHIFT - 1));
    rnd    = biased[PW2-1:ROUND_SHIFT];
    neg    = -NW'(rnd);
    if (neg > NW'(SAT_MAX)) begin
      coord_nxt = SAT_MAX;
    end else if (neg < NW'(SAT_MIN)) begin
      coord_nxt = SAT_MIN;
    end else begin
      coord_nxt = neg[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      prod1_r <= prod1_nxt;
    end
    if (en.s2) begin
      prod2_r <= prod1_r * $signed({1'b0, inv});
    end
    if (en.s3) begin
      coord_r <= coord_nxt;
    end
  end

endmodule

>>> rtl/core/dpdpc_height.sv
module dpdpc_height
  import dpdpc_pkg::*;
#(
  parameter int DEPTH_BITS = 16
) (
  input  logic                          clk,
  input  height_en_t                    en,
  input  logic [DEPTH_BITS-1:0]         forward,
  input  logic signed [COORD_W-1:0]     left,
  input  logic signed [COORD_W-1:0]     up,
  input  logic signed [PLANE_BITS-1:0]  plane_a,
  input  logic signed [PLANE_BITS-1:0]  plane_b,
  input  logic signed [PLANE_BITS-1:0]  plane_c,
  input  logic signed [OFFSET_BITS-1:0] offset,
  output logic                          keep_r
);

  localparam int AW = DEPTH_BITS + 1 + PLANE_BITS;
  localparam int BW = COORD_W + PLANE_BITS;
  localparam int SW = BW + 2;

  logic signed [AW-1:0] pa_r;
  logic signed [BW-1:0] pb_r;
  logic signed [BW-1:0] pc_r;
  logic                 nonzero_r;
  logic signed [SW-1:0] height;
  logic                 keep_nxt;

  // The threshold is compared in Q16 so the test stays exact.
  always_comb begin
    height = SW'(pa_r) + SW'(pb_r) + SW'(pc_r) + (SW'(offset) <<< PLANE_SHIFT);
    keep_nxt = nonzero_r && (height >= (SW'(HEIGHT_MIN_MM) <<< PLANE_SHIFT));
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      pa_r      <= $signed({1'b0, forward}) * plane_a;
      pb_r      <= left * plane_b;
      pc_r      <= up * plane_c;
      nonzero_r <= (forward != '0);
    end
    if (en.s5) begin
      keep_r <= keep_nxt;
    end
  end

endmodule

>>> rtl/core/dpdpc_checker.sv
module dpdpc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_keep,
  input logic [15:0]        out_forward,
  input logic signed [23:0] out_left,
  input logic signed [23:0] out_up
);

  // A result with no depth has no coordinates and is never kept.
  a_zero_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_forward == 16'd0 |-> !out_keep && out_left == 24'sd0 && out_up == 24'sd0)
    else $error("zero-depth result carries a point or keep");

  // When the output drains, every stage can move, so the input side must be open.
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result keeps its point.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_left) && $stable(out_up)
      && $stable(out_keep))
    else $error("stalled result changed");

endmodule

bind depth_pixel_deproject_plane_clip_core dpdpc_checker u_dpdpc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_keep    (out_ch.keep),
  .out_forward (out_ch.point_forward),
  .out_left    (out_ch.point_left),
  .out_up      (out_ch.point_up)
);

>>> dv/tb_depth_pixel_deproject_plane_clip_core.sv
// Testbench for the depth pixel deprojection core. A scripted list of pixels and
// register writes runs first, then eight phases of random pixels under freshly drawn
// camera and plane settings. Each accepted pixel gets a prediction, either typed
// into the script or from a local model of the pinhole deprojection and height test,
// and every result transfer is checked against the oldest pending prediction.
module tb_depth_pixel_deproject_plane_clip_core;
  import dpdpc_pkg::*;

  localparam int N_PHASES         = 8;
  localparam int PHASE_ITEMS      = 210;
  // Five register stages in the core, plus some slack.
  localparam int DRAIN_CYCLES     = 8;
  localparam int LONG_HOLD_CYCLES = 150;
  localparam int LONG_HOLD_AFTER  = 500;

  typedef struct packed {
    logic [15:0] depth;
    logic [11:0] col;
    logic [11:0] row;
    logic        last;
  } pixel_t;

  typedef struct packed {
    logic               keep;
    logic [15:0]        forward;
    logic signed [23:0] left;
    logic signed [23:0] up;
    logic               last;
  } point_t;

  // One line of the scripted opening: either a register write or a pixel. A pixel
  // carries its result only when it is obvious by inspection; otherwise the model
  // below supplies it.
  typedef struct {
    bit                         is_cfg;
    cfg_reg_e                   reg_idx;
    logic [CFG_DATA_BITS-1:0]   wdata;
    pixel_t                     px;
    bit                         typed;
    point_t                     want;
  } plan_row_t;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;

  dpdpc_in_if #(.COORD_BITS(12), .DEPTH_BITS(16)) in_ch ();
  dpdpc_out_if out_ch ();

  depth_pixel_deproject_plane_clip_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Local copy of the register file, kept at the widths of the hardware.
  logic [CENTER_BITS-1:0]        cam_cx;
  logic [CENTER_BITS-1:0]        cam_cy;
  logic [INV_BITS-1:0]           cam_inv_x;
  logic [INV_BITS-1:0]           cam_inv_y;
  logic signed [PLANE_BITS-1:0]  plane_a;
  logic signed [PLANE_BITS-1:0]  plane_b;
  logic signed [PLANE_BITS-1:0]  plane_c;
  logic signed [OFFSET_BITS-1:0] plane_off;

  point_t    expected_points[$];
  plan_row_t plan[$];

  int n_errors   = 0;
  int n_results  = 0;
  int burst_left = 0;
  int gap_max    = 4;

  logic [15:0] rx_cycle;
  int          hold_left;
  bit          hold_done;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // The run is far shorter than this even with every stall at its longest; reaching it
  // means the core stopped producing results.
  initial begin
    #1000000;
    $display("[depth_pixel_deproject_plane_clip_core] ERROR");
    $finish;
  end

  // Offset of one axis in mm: depth times the Q4 pixel offset from the principal
  // point times the Q24 reciprocal gives Q28. Rounding is half up, which for a signed
  // value means adding one half and then taking the floor via an arithmetic shift.
  function automatic longint axis_offset_mm(longint depth, longint pix, longint center,
                                            longint inv);
    longint prod;
    prod = depth * ((pix <<< Q4_SHIFT) - center) * inv;
    return (prod + (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
  endfunction

  function automatic logic signed [COORD_W-1:0] clamp_coord(longint v);
    if (v > SAT_MAX) return SAT_MAX;
    if (v < SAT_MIN) return SAT_MIN;
    return v[COORD_W-1:0];
  endfunction

  // Expected point for one pixel under the current register copy. The height test is
  // done exactly in Q16, on the already clamped left and up coordinates.
  function automatic point_t deproject_pixel(pixel_t px);
    point_t pt;
    longint depth;
    longint lf;
    longint up;
    longint wa;
    longint wb;
    longint wc;
    longint off;
    longint height;
    depth = px.depth;
    pt.left = clamp_coord(-axis_offset_mm(depth, px.col, cam_cx, cam_inv_x));
    pt.up = clamp_coord(-axis_offset_mm(depth, px.row, cam_cy, cam_inv_y));
    lf = pt.left;
    up = pt.up;
    wa = plane_a;
    wb = plane_b;
    wc = plane_c;
    off = plane_off;
    height = depth * wa + lf * wb + up * wc + (off <<< PLANE_SHIFT);
    pt.keep = (depth != 0) && (height >= (longint'(HEIGHT_MIN_MM) <<< PLANE_SHIFT));
    pt.forward = px.depth;
    pt.last = px.last;
    return pt;
  endfunction

  function automatic plan_row_t cfg_row(cfg_reg_e idx, logic [CFG_DATA_BITS-1:0] data);
    plan_row_t r;
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.wdata = data;
    r.px = '0;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic plan_row_t pix_row(logic [15:0] d, logic [11:0] c, logic [11:0] rw,
                                        logic l);
    plan_row_t r;
    r.is_cfg = 1'b0;
    r.reg_idx = REG_CENTER_X;
    r.wdata = '0;
    r.px = '{depth: d, col: c, row: rw, last: l};
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic plan_row_t pix_known(logic [15:0] d, logic [11:0] c, logic [11:0] rw,
                                          logic l, logic k, logic signed [23:0] lf,
                                          logic signed [23:0] u);
    plan_row_t r;
    r = pix_row(d, c, rw, l);
    r.typed = 1'b1;
    r.want = '{keep: k, forward: d, left: lf, up: u, last: l};
    return r;
  endfunction

  // Appends one line to the scripted opening.
  function automatic void add_row(plan_row_t r);
    plan.insert(plan.size(), r);
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t px;
    // Zero depth and full-scale depth each get a tenth of the draws, small depths
    // another tenth, so that rounding near zero is exercised as well.
    case ($urandom_range(0, 9))
      0: px.depth = '0;
      1: px.depth = '1;
      2: px.depth = 16'($urandom_range(1, 255));
      default: px.depth = 16'($urandom());
    endcase
    px.col = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 12'hFFF : 12'h000)
                                         : 12'($urandom());
    px.row = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 12'hFFF : 12'h000)
                                         : 12'($urandom());
    px.last = ($urandom_range(0, 15) == 0);
    return px;
  endfunction

  task automatic report_field(string what, longint want, longint got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    n_errors++;
  endtask

  // Waits until every predicted result has been seen, then lets the pipeline settle.
  task automatic wait_drained();
    while (expected_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Drives one register write. The write enable is left high so that back-to-back
  // writes stay one transfer per clock; the caller lowers it after the last one.
  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_CENTER_X:     cam_cx = data[CENTER_BITS-1:0];
      REG_CENTER_Y:     cam_cy = data[CENTER_BITS-1:0];
      REG_INV_FOCAL_X:  cam_inv_x = data[INV_BITS-1:0];
      REG_INV_FOCAL_Y:  cam_inv_y = data[INV_BITS-1:0];
      REG_PLANE_A:      plane_a = data[PLANE_BITS-1:0];
      REG_PLANE_B:      plane_b = data[PLANE_BITS-1:0];
      REG_PLANE_C:      plane_c = data[PLANE_BITS-1:0];
      REG_PLANE_OFFSET: plane_off = data[OFFSET_BITS-1:0];
      default: ;
    endcase
  endtask

  // Draws a full register set and writes it. Mode 0 looks like a real camera with a
  // gently tilted floor plane, so keep comes out both ways; mode 1 is anything at all;
  // mode 2 takes every register from its corners. Unused high bits of the narrower
  // registers carry random junk, which the core must ignore.
  task automatic retune_camera(int mode);
    logic [CFG_DATA_BITS-1:0] v [8];
    logic [CFG_DATA_BITS-1:0] mask;
    case (mode)
      0: begin
        v[0] = 32'(5120 + $urandom_range(0, 2048) - 1024);
        v[1] = 32'(3840 + $urandom_range(0, 2048) - 1024);
        v[2] = 32'($urandom_range(20000, 60000));
        v[3] = 32'($urandom_range(20000, 60000));
        v[4] = 32'($urandom_range(0, 262144)) - 32'd131072;
        v[5] = 32'($urandom_range(0, 262144)) - 32'd131072;
        v[6] = 32'($urandom_range(0, 262144)) - 32'd131072;
        v[7] = 32'($urandom_range(0, 4000)) - 32'd2000;
      end
      1: begin
        for (int i = 0; i < 8; i++) v[i] = $urandom();
      end
      default: begin
        v[0] = $urandom_range(0, 1) ? 32'h0000FFFF : 32'h0;
        v[1] = $urandom_range(0, 1) ? 32'h0000FFFF : 32'h0;
        v[2] = $urandom_range(0, 1) ? 32'h00FFFFFF : 32'h1;
        v[3] = $urandom_range(0, 1) ? 32'h00FFFFFF : 32'h1;
        for (int i = 4; i < 7; i++) begin
          case ($urandom_range(0, 3))
            0: v[i] = 32'h80000000;
            1: v[i] = 32'h7FFFFFFF;
            2: v[i] = 32'h0;
            default: v[i] = 32'h00010000;
          endcase
        end
        case ($urandom_range(0, 2))
          0: v[7] = 32'h00800000;
          1: v[7] = 32'h007FFFFF;
          default: v[7] = 32'h0;
        endcase
      end
    endcase
    for (int i = 0; i < 8; i++) begin
      case (cfg_reg_e'(i))
        REG_CENTER_X, REG_CENTER_Y: mask = 32'h0000FFFF;
        REG_PLANE_A, REG_PLANE_B, REG_PLANE_C: mask = 32'hFFFFFFFF;
        default: mask = 32'h00FFFFFF;
      endcase
      write_reg(cfg_reg_e'(i), (v[i] & mask) | ($urandom() & ~mask));
    end
    cfg_we <= 1'b0;
  endtask

  // Offers one pixel and holds it until the core takes it. The prediction is queued
  // at the accepting edge, so queue order is transfer order.
  task automatic send_pixel(pixel_t px, point_t want);
    in_ch.valid <= 1'b1;
    in_ch.depth_mm <= px.depth;
    in_ch.pixel_col <= px.col;
    in_ch.pixel_row <= px.row;
    in_ch.frame_last <= px.last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_points.insert(expected_points.size(), want);
  endtask

  // Sender pacing after each accepted pixel: bursts of random length separated by
  // random gaps. With drain set, valid drops and the sender waits for every result,
  // which is how phases end and how the mid-run pause is made.
  task automatic pace_sender(bit drain);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = $urandom_range(0, gap_max);
    end else begin
      gap = 0;
    end
    burst_left--;
    if (gap != 0 || drain) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      if (drain) wait_drained();
    end
  endtask

  // Result side ready. It cycles through four patterns in turn: always ready,
  // mostly ready, mostly stalled, and a fixed toggle. Once, after a few hundred
  // results, it stalls for a long stretch so the pipeline fills and pushes back on
  // the pixel input while the sender keeps offering.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_cycle <= '0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 16'd1;
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (!hold_done && n_results >= LONG_HOLD_AFTER) begin
        out_ch.ready <= 1'b0;
        hold_left <= LONG_HOLD_CYCLES;
        hold_done <= 1'b1;
      end else begin
        case (rx_cycle[8:7])
          2'd0: out_ch.ready <= 1'b1;
          2'd1: out_ch.ready <= ($urandom_range(0, 3) != 0);
          2'd2: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= rx_cycle[1] ^ rx_cycle[4];
        endcase
      end
    end
  end

  // Result checker. Signals are read right at the clock edge, before any update of
  // that edge lands, so a transfer is seen exactly when it happens.
  always @(posedge clk) begin : check_results
    point_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results <= n_results + 1;
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected result, expected none, got keep=%0d forward=%0d %s%0d %s%0d",
                 $time, out_ch.keep, out_ch.point_forward, "left=", out_ch.point_left,
                 "up=", out_ch.point_up);
        n_errors++;
      end else begin
        want = expected_points.pop_front();
        if (out_ch.keep !== want.keep) report_field("keep", want.keep, out_ch.keep);
        if (out_ch.point_forward !== want.forward)
          report_field("point_forward", want.forward, out_ch.point_forward);
        if (out_ch.point_left !== want.left)
          report_field("point_left", want.left, out_ch.point_left);
        if (out_ch.point_up !== want.up) report_field("point_up", want.up, out_ch.point_up);
        if (out_ch.result_last !== want.last)
          report_field("result_last", want.last, out_ch.result_last);
      end
    end
  end

  initial begin : stimulus
    pixel_t px;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_CENTER_X;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.depth_mm = '0;
    in_ch.pixel_col = '0;
    in_ch.pixel_row = '0;
    in_ch.frame_last = 1'b0;

    cam_cx = CENTER_X_RST;
    cam_cy = CENTER_Y_RST;
    cam_inv_x = INV_FOCAL_RST;
    cam_inv_y = INV_FOCAL_RST;
    plane_a = '0;
    plane_b = '0;
    plane_c = '0;
    plane_off = '0;

    // Reset values: the principal point is pixel (320, 240) and the plane is all
    // zero, so nothing is ever kept. Zero depth gives an all-zero point, and a pixel
    // on the principal point has no lateral or vertical offset at any depth.
    add_row(pix_known(16'd0, 12'd0, 12'd0, 1'b0, 1'b0, 24'sd0, 24'sd0));
    add_row(pix_known(16'd0, 12'hFFF, 12'hFFF, 1'b1, 1'b0, 24'sd0, 24'sd0));
    add_row(pix_known(16'hFFFF, 12'd320, 12'd240, 1'b0, 1'b0, 24'sd0, 24'sd0));
    add_row(pix_known(16'd1, 12'd320, 12'd240, 1'b0, 1'b0, 24'sd0, 24'sd0));
    add_row(pix_row(16'hFFFF, 12'd0, 12'd0, 1'b0));
    add_row(pix_row(16'hFFFF, 12'hFFF, 12'hFFF, 1'b1));
    add_row(pix_row(16'd1000, 12'd0, 12'hFFF, 1'b0));

    // Principal point in the corner and the largest reciprocals: the far corner
    // clamps both coordinates to the negative limit. Junk in the high bits of the
    // center write must be dropped.
    add_row(cfg_row(REG_CENTER_X, 32'hFFFF0000));
    add_row(cfg_row(REG_CENTER_Y, 32'h00000000));
    add_row(cfg_row(REG_INV_FOCAL_X, 32'h00FFFFFF));
    add_row(cfg_row(REG_INV_FOCAL_Y, 32'h00FFFFFF));
    add_row(pix_known(16'hFFFF, 12'hFFF, 12'hFFF, 1'b1, 1'b0, SAT_MIN, SAT_MIN));
    add_row(pix_known(16'hFFFF, 12'd0, 12'd0, 1'b0, 1'b0, 24'sd0, 24'sd0));
    add_row(pix_row(16'd1, 12'd1, 12'd1, 1'b0));

    // Principal point beyond the image: pixel 0 clamps to the positive limit.
    add_row(cfg_row(REG_CENTER_X, 32'h0000FFFF));
    add_row(cfg_row(REG_CENTER_Y, 32'h0000FFFF));
    add_row(pix_known(16'hFFFF, 12'd0, 12'd0, 1'b0, 1'b0, SAT_MAX, SAT_MAX));

    // Zero reciprocals flatten both coordinates to zero.
    add_row(cfg_row(REG_INV_FOCAL_X, 32'hFF000000));
    add_row(cfg_row(REG_INV_FOCAL_Y, 32'h00000000));
    add_row(pix_known(16'd40000, 12'd100, 12'd4000, 1'b0, 1'b0, 24'sd0, 24'sd0));

    // Height equals forward: exactly 50 mm is kept, 49 mm is not, zero depth never.
    add_row(cfg_row(REG_CENTER_X, 32'd5120));
    add_row(cfg_row(REG_CENTER_Y, 32'd3840));
    add_row(cfg_row(REG_INV_FOCAL_X, 32'd27962));
    add_row(cfg_row(REG_INV_FOCAL_Y, 32'd27962));
    add_row(cfg_row(REG_PLANE_A, 32'h00010000));
    add_row(pix_known(16'd50, 12'd320, 12'd240, 1'b0, 1'b1, 24'sd0, 24'sd0));
    add_row(pix_known(16'd49, 12'd320, 12'd240, 1'b0, 1'b0, 24'sd0, 24'sd0));
    add_row(pix_known(16'd0, 12'd320, 12'd240, 1'b1, 1'b0, 24'sd0, 24'sd0));

    // Plane weights and offset at their limits. The huge offset alone would keep the
    // point, but zero depth still rejects it.
    add_row(cfg_row(REG_PLANE_A, 32'h80000000));
    add_row(cfg_row(REG_PLANE_B, 32'h7FFFFFFF));
    add_row(cfg_row(REG_PLANE_C, 32'h80000000));
    add_row(cfg_row(REG_PLANE_OFFSET, 32'hFF7FFFFF));
    add_row(pix_known(16'd0, 12'd0, 12'd0, 1'b0, 1'b0, 24'sd0, 24'sd0));
    add_row(pix_row(16'hFFFF, 12'hFFF, 12'd0, 1'b0));
    add_row(pix_row(16'hFFFF, 12'd0, 12'hFFF, 1'b1));

    add_row(cfg_row(REG_PLANE_A, 32'h7FFFFFFF));
    add_row(cfg_row(REG_PLANE_OFFSET, 32'h00800000));
    add_row(pix_row(16'hFFFF, 12'd320, 12'd240, 1'b0));
    add_row(pix_row(16'd12345, 12'd2048, 12'd1024, 1'b1));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Scripted opening. Each pixel before a register write drains the core, so the
    // registers only ever change while nothing is in flight.
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        write_reg(plan[i].reg_idx, plan[i].wdata);
        if (i + 1 == plan.size() || !plan[i + 1].is_cfg) cfg_we <= 1'b0;
      end else begin
        send_pixel(plan[i].px, plan[i].typed ? plan[i].want : deproject_pixel(plan[i].px));
        pace_sender(i + 1 == plan.size() || plan[i + 1].is_cfg);
      end
    end

    // Random phases. Phase 4 has no sender gaps at all; phase 1 also pauses halfway
    // until every result has come back.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      retune_camera(ph % 3);
      gap_max = (ph == 4) ? 0 : ((ph % 2 != 0) ? 3 : 8);
      burst_left = 0;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        px = random_pixel();
        send_pixel(px, deproject_pixel(px));
        pace_sender(k == PHASE_ITEMS - 1 || (ph == 1 && k == PHASE_ITEMS / 2));
      end
    end

    // The last phase ended with a full drain, so nothing is pending here.
    if (n_errors == 0) begin
      $display("[depth_pixel_deproject_plane_clip_core] OK");
    end else begin
      $display("[depth_pixel_deproject_plane_clip_core] ERROR");
    end
    $finish;
  end

endmodule

>>> depth_pixel_deproject_plane_clip_core.f
rtl/core/dpdpc_pkg.sv
rtl/core/dpdpc_in_if.sv
rtl/core/dpdpc_out_if.sv
rtl/core/dpdpc_axis.sv
rtl/core/dpdpc_height.sv
rtl/core/depth_pixel_deproject_plane_clip_core.sv
rtl/core/dpdpc_checker.sv
dv/tb_depth_pixel_deproject_plane_clip_core.sv
